// ===== rtl/chtpr_pkg.sv =====
// chtpr_pkg: shared types and constants of the clustered hash table probe/replace core
// used by the top level, chtpr_front and chtpr_back; depends on nothing else

package chtpr_pkg;

   localparam int KEY_W        = 64;
   localparam int CHUNK_W      = 8;
   localparam int CLUSTERS_DEF = 1024;
   localparam int WAYS_DEF     = 4;
   localparam int QUEUE_DEPTH  = 2;

   localparam logic ACT_FETCH = 1'b0;
   localparam logic ACT_SAVE  = 1'b1;

   typedef struct packed {
      logic               action;
      logic [KEY_W-1:0]   key;
      logic [7:0]         depth;
      logic [7:0]         bound;
      logic [7:0]         age;
      logic [15:0]        best_move;
      logic signed [15:0] score;
      logic               pv_node;
   } req_type;

   typedef struct packed {
      logic               valid;
      logic [KEY_W-1:0]   key;
      logic [7:0]         depth;
      logic [7:0]         bound;
      logic [7:0]         age;
      logic [15:0]        move;
      logic signed [15:0] score;
   } entry_type;

endpackage

// ===== rtl/clustered_hash_table_probe_replace_core.sv =====
// clustered_hash_table_probe_replace_core: top level of the set-associative search table
// uses chtpr_pkg, chtpr_front, chtpr_queue and chtpr_back

// A request is taken when start is high and busy is low. A fetch returns one
// result on the rsp_ ports, marked by rsp_valid for a single cycle, once it has
// passed the front register, the queue, the cluster row read and the result
// register; a save returns nothing. The receiver cannot stall results. For each
// request the back end first reads the cluster row from memory, then compares
// the ways and either answers or writes the row back, and only then takes the
// next request. With a power-of-two CLUSTERS the front end forwards a request
// each cycle into a two-deep queue while the queue is not full; otherwise the
// cluster index is a residue of the key formed one key byte a cycle, and the
// front end takes no new request until it has pushed the last one. After reset
// the table is cleared one cluster row a cycle, and busy stays high for that whole pass.

module clustered_hash_table_probe_replace_core #(
   parameter int CLUSTERS = chtpr_pkg::CLUSTERS_DEF,
   parameter int WAYS     = chtpr_pkg::WAYS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic               req_action,
   input  logic [63:0]        req_key,
   input  logic [7:0]         req_depth,
   input  logic [7:0]         req_bound,
   input  logic [7:0]         req_age,
   input  logic [15:0]        req_best_move,
   input  logic signed [15:0] req_score,
   input  logic               req_pv_node,
   output logic               rsp_valid,
   output logic               rsp_hit,
   output logic [7:0]         rsp_out_depth,
   output logic [7:0]         rsp_out_bound,
   output logic [7:0]         rsp_out_age,
   output logic [15:0]        rsp_out_move,
   output logic signed [15:0] rsp_out_score
);

   localparam int IDX_W = (CLUSTERS > 1) ? $clog2(CLUSTERS) : 1;
   localparam int Q_W   = $bits(chtpr_pkg::req_type) + IDX_W;

   chtpr_pkg::req_type req;
   chtpr_pkg::req_type push_req;
   chtpr_pkg::req_type pop_req;
   logic [IDX_W-1:0]   push_idx;
   logic [IDX_W-1:0]   pop_idx;
   logic               push;
   logic               q_full;
   logic               q_pop;
   logic               q_valid;
   logic               clear_active;
   logic [Q_W-1:0]     pop_data;

   assign req.action    = req_action;
   assign req.key       = req_key;
   assign req.depth     = req_depth;
   assign req.bound     = req_bound;
   assign req.age       = req_age;
   assign req.best_move = req_best_move;
   assign req.score     = req_score;
   assign req.pv_node   = req_pv_node;

   chtpr_front #(
      .CLUSTERS (CLUSTERS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .hold     (clear_active),
      .req      (req),
      .busy     (busy),
      .q_full   (q_full),
      .push     (push),
      .push_idx (push_idx),
      .push_req (push_req)
   );

   chtpr_queue #(
      .WIDTH (Q_W),
      .DEPTH (chtpr_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data ({push_idx, push_req}),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (pop_data),
      .not_empty (q_valid)
   );

   assign pop_idx = pop_data[Q_W-1 -: IDX_W];
   assign pop_req = pop_data[$bits(chtpr_pkg::req_type)-1:0];

   chtpr_back #(
      .CLUSTERS (CLUSTERS),
      .WAYS     (WAYS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .q_valid       (q_valid),
      .q_idx         (pop_idx),
      .q_req         (pop_req),
      .q_pop         (q_pop),
      .clear_active  (clear_active),
      .rsp_valid     (rsp_valid),
      .rsp_hit       (rsp_hit),
      .rsp_out_depth (rsp_out_depth),
      .rsp_out_bound (rsp_out_bound),
      .rsp_out_age   (rsp_out_age),
      .rsp_out_move  (rsp_out_move),
      .rsp_out_score (rsp_out_score)
   );

   // no request taken while the table is being cleared
   a_busy_in_clear: assert property (@(posedge clock) disable iff (reset)
      clear_active |-> busy)
      else $error("request port open during table clear");

   // the back end returns to idle after each request, so results never come back to back
   a_rsp_spacing: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("results on consecutive cycles");

   a_no_rsp_in_clear: assert property (@(posedge clock) disable iff (reset)
      clear_active |-> !rsp_valid)
      else $error("result during table clear");

   // a miss carries all-zero fields
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_hit) |-> (rsp_out_depth == '0 && rsp_out_bound == '0 &&
                                   rsp_out_age == '0 && rsp_out_move == '0 &&
                                   rsp_out_score == '0))
      else $error("miss with nonzero fields");

endmodule

// ===== rtl/chtpr_queue.sv =====
// chtpr_queue: small fifo between the front and the back of the core
// generic width and depth; no package dependency

module chtpr_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             not_empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_data  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/chtpr_front.sv =====
// chtpr_front: takes requests and works out the cluster index of the key
// uses chtpr_pkg; feeds chtpr_queue

module chtpr_front #(
   parameter int  CLUSTERS = chtpr_pkg::CLUSTERS_DEF,
   localparam int IDX_W    = (CLUSTERS > 1) ? $clog2(CLUSTERS) : 1
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               hold,
   input  chtpr_pkg::req_type req,
   output logic               busy,
   input  logic               q_full,
   output logic               push,
   output logic [IDX_W-1:0]   push_idx,
   output chtpr_pkg::req_type push_req
);

   localparam bit             IS_POW2 = ((CLUSTERS & (CLUSTERS - 1)) == 0);
   localparam int             STEPS   = chtpr_pkg::KEY_W / chtpr_pkg::CHUNK_W;
   localparam int             STEP_W  = $clog2(STEPS);
   localparam logic [IDX_W:0] CL_EXT  = (IDX_W + 1)'(CLUSTERS);
   localparam logic [IDX_W-1:0] IDX_MASK = IDX_W'(CLUSTERS - 1);

   logic                 full_ff;
   logic                 fin_ff;
   logic [STEP_W-1:0]    step_ff;
   logic [IDX_W-1:0]     rem_ff;
   logic [IDX_W-1:0]     rem_in;
   chtpr_pkg::req_type   req_ff;
   logic                 accept;

   assign push     = full_ff && fin_ff && !q_full;
   assign busy     = hold || (full_ff && !push);
   assign accept   = start && !busy;
   assign push_idx = rem_ff;
   assign push_req = req_ff;

   // residue of the key by the cluster count, one key byte a cycle, msb first
   always_comb begin
      logic [chtpr_pkg::CHUNK_W-1:0] chunk;
      logic [IDX_W-1:0]              r;
      logic [IDX_W:0]                t;
      chunk = req_ff.key[chtpr_pkg::KEY_W - 1 - chtpr_pkg::CHUNK_W * step_ff -:
                         chtpr_pkg::CHUNK_W];
      r = rem_ff;
      for (int b = chtpr_pkg::CHUNK_W - 1; b >= 0; b--) begin
         t = {r, chunk[b]};
         if (t >= CL_EXT) begin
            t = t - CL_EXT;
         end
         r = t[IDX_W-1:0];
      end
      rem_in = r;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         full_ff <= 1'b0;
         fin_ff  <= 1'b0;
         step_ff <= '0;
      end else if (accept) begin
         full_ff <= 1'b1;
         fin_ff  <= IS_POW2;
         step_ff <= '0;
      end else begin
         if (push) begin
            full_ff <= 1'b0;
         end
         if (full_ff && !fin_ff) begin
            step_ff <= step_ff + 1'b1;
            if (step_ff == STEP_W'(STEPS - 1)) begin
               fin_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req;
         if (IS_POW2) begin
            rem_ff <= req.key[IDX_W-1:0] & IDX_MASK;
         end else begin
            rem_ff <= '0;
         end
      end else if (full_ff && !fin_ff) begin
         rem_ff <= rem_in;
      end
   end

endmodule

// ===== rtl/chtpr_back.sv =====
// chtpr_back: cluster memory, way compare, fetch response and save write-back
// uses chtpr_pkg; drains chtpr_queue

module chtpr_back #(
   parameter int  CLUSTERS = chtpr_pkg::CLUSTERS_DEF,
   parameter int  WAYS     = chtpr_pkg::WAYS_DEF,
   localparam int IDX_W    = (CLUSTERS > 1) ? $clog2(CLUSTERS) : 1
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_valid,
   input  logic [IDX_W-1:0]   q_idx,
   input  chtpr_pkg::req_type q_req,
   output logic               q_pop,
   output logic               clear_active,
   output logic               rsp_valid,
   output logic               rsp_hit,
   output logic [7:0]         rsp_out_depth,
   output logic [7:0]         rsp_out_bound,
   output logic [7:0]         rsp_out_age,
   output logic [15:0]        rsp_out_move,
   output logic signed [15:0] rsp_out_score
);

   localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;

   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_EVAL  = 2'd2;

   typedef chtpr_pkg::entry_type [WAYS-1:0] row_type;

   row_type             mem [CLUSTERS];
   row_type             rd_row_ff;
   row_type             wr_row;
   row_type             wr_data;
   logic                wr_en;
   logic [IDX_W-1:0]    wr_idx;

   logic [1:0]          state_ff, state_in;
   logic [IDX_W-1:0]    clr_ff, clr_in;
   logic [IDX_W-1:0]    widx_ff;
   chtpr_pkg::req_type  work_ff;

   logic                found;
   chtpr_pkg::entry_type hit_entry;
   logic [WAY_W-1:0]    pick;

   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_hit_ff;
   chtpr_pkg::entry_type rsp_entry_ff, rsp_entry_in;

   assign clear_active = (state_ff == ST_CLEAR);
   assign q_pop        = (state_ff == ST_IDLE) && q_valid;

   // compare every way of the cluster read last cycle
   always_comb begin
      logic             inval_any;
      logic [WAY_W-1:0] inval_w;
      logic             cand_any;
      logic [WAY_W-1:0] cand_w;
      logic             match;
      logic signed [9:0] age_gap;
      chtpr_pkg::entry_type fresh;
      found     = 1'b0;
      hit_entry = '0;
      inval_any = 1'b0;
      inval_w   = '0;
      cand_any  = 1'b0;
      cand_w    = '0;
      // downward scans leave the lowest way
      for (int w = WAYS - 1; w >= 0; w--) begin
         if (rd_row_ff[w].valid && rd_row_ff[w].key == work_ff.key) begin
            found     = 1'b1;
            hit_entry = rd_row_ff[w];
         end
         if (!rd_row_ff[w].valid) begin
            inval_any = 1'b1;
            inval_w   = WAY_W'(w);
         end
      end
      // upward scan leaves the last replaceable match
      for (int w = 0; w < WAYS; w++) begin
         match   = rd_row_ff[w].valid && rd_row_ff[w].key == work_ff.key;
         age_gap = $signed({2'b00, work_ff.age}) - $signed({2'b00, rd_row_ff[w].age});
         if (match && ((age_gap > 10'sd1) ||
                       (rd_row_ff[w].depth > work_ff.depth && work_ff.pv_node))) begin
            cand_any = 1'b1;
            cand_w   = WAY_W'(w);
         end
      end
      if (inval_any) begin
         pick = inval_w;
      end else if (cand_any) begin
         pick = cand_w;
      end else begin
         pick = '0;
      end
      fresh.valid = 1'b1;
      fresh.key   = work_ff.key;
      fresh.depth = work_ff.depth;
      fresh.bound = work_ff.bound;
      fresh.age   = work_ff.age;
      fresh.move  = work_ff.best_move;
      fresh.score = work_ff.score;
      wr_row       = rd_row_ff;
      wr_row[pick] = fresh;
   end

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      rsp_valid_in = 1'b0;
      rsp_entry_in = found ? hit_entry : '0;
      wr_en        = 1'b0;
      wr_idx       = widx_ff;
      wr_data      = wr_row;
      unique case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_idx  = clr_ff;
            wr_data = '0;
            clr_in  = clr_ff + 1'b1;
            if (clr_ff == IDX_W'(CLUSTERS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (q_valid) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            state_in = ST_IDLE;
            if (work_ff.action == chtpr_pkg::ACT_SAVE) begin
               wr_en = 1'b1;
            end else begin
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         work_ff <= q_req;
         widx_ff <= q_idx;
      end
      if (rsp_valid_in) begin
         rsp_hit_ff   <= found;
         rsp_entry_ff <= rsp_entry_in;
      end
   end

   // cluster memory, one row read and one row written per cycle
   always_ff @(posedge clock) begin
      if (q_pop) begin
         rd_row_ff <= mem[q_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= wr_data;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_hit       = rsp_hit_ff;
   assign rsp_out_depth = rsp_entry_ff.depth;
   assign rsp_out_bound = rsp_entry_ff.bound;
   assign rsp_out_age   = rsp_entry_ff.age;
   assign rsp_out_move  = rsp_entry_ff.move;
   assign rsp_out_score = rsp_entry_ff.score;

endmodule

// ===== bench/chtpr_checker.sv =====
// chtpr_checker: watches the request and response ports of the probe/replace core,
// keeps its own copy of the clustered table and checks every fetch answer in order
// depends on chtpr_pkg
`timescale 1ns / 1ps

module chtpr_checker #(
   parameter int CLUSTERS = chtpr_pkg::CLUSTERS_DEF,
   parameter int WAYS     = chtpr_pkg::WAYS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               busy,
   input  logic               req_action,
   input  logic [63:0]        req_key,
   input  logic [7:0]         req_depth,
   input  logic [7:0]         req_bound,
   input  logic [7:0]         req_age,
   input  logic [15:0]        req_best_move,
   input  logic signed [15:0] req_score,
   input  logic               req_pv_node,
   input  logic               rsp_valid,
   input  logic               rsp_hit,
   input  logic [7:0]         rsp_out_depth,
   input  logic [7:0]         rsp_out_bound,
   input  logic [7:0]         rsp_out_age,
   input  logic [15:0]        rsp_out_move,
   input  logic signed [15:0] rsp_out_score,
   output int                 fail_count,
   output int                 answers_owed
);

   typedef struct packed {
      logic               hit;
      logic [7:0]         depth;
      logic [7:0]         bound;
      logic [7:0]         age;
      logic [15:0]        move;
      logic signed [15:0] score;
   } fetch_answer_type;

   chtpr_pkg::entry_type slot_table [CLUSTERS*WAYS];
   fetch_answer_type     fetch_answers [$];

   initial begin
      fail_count   = 0;
      answers_owed = 0;
   end

   task automatic report_error(string msg);
      $display("%0t ns: %s", $time, msg);
      fail_count++;
   endtask

   task automatic check_field(string name, int got, int want);
      if (got != want) begin
         report_error($sformatf("%s got %0d want %0d", name, got, want));
      end
   endtask

   function automatic int cluster_base(logic [63:0] key);
      return int'(key % 64'(CLUSTERS)) * WAYS;
   endfunction

   // first valid way with an equal key answers; nothing found gives all zero
   function automatic fetch_answer_type look_up(logic [63:0] key);
      fetch_answer_type     ans;
      chtpr_pkg::entry_type e;
      int                   base;
      base = cluster_base(key);
      ans  = '0;
      for (int w = WAYS - 1; w >= 0; w--) begin
         e = slot_table[base + w];
         if (e.valid && e.key == key) begin
            ans.hit   = 1'b1;
            ans.depth = e.depth;
            ans.bound = e.bound;
            ans.age   = e.age;
            ans.move  = e.move;
            ans.score = e.score;
         end
      end
      return ans;
   endfunction

   function automatic void store_entry(logic [63:0] key, logic [7:0] depth, logic [7:0] bound,
                                       logic [7:0] age, logic [15:0] move,
                                       logic signed [15:0] score, logic pv);
      chtpr_pkg::entry_type e;
      int                   base;
      int                   pick;
      logic                 empty_found;
      base        = cluster_base(key);
      pick        = 0;
      empty_found = 1'b0;
      for (int w = 0; w < WAYS; w++) begin
         e = slot_table[base + w];
         if (!empty_found) begin
            if (!e.valid) begin
               pick        = w;
               empty_found = 1'b1;
            end else if (e.key == key) begin
               // stale by more than one generation, or deeper and kept for a pv node
               if (int'(age) - int'(e.age) > 1) begin
                  pick = w;
               end else if (e.depth > depth && pv) begin
                  pick = w;
               end
            end
         end
      end
      e.valid = 1'b1;
      e.key   = key;
      e.depth = depth;
      e.bound = bound;
      e.age   = age;
      e.move  = move;
      e.score = score;
      slot_table[base + pick] = e;
   endfunction

   always @(posedge clock) begin
      fetch_answer_type want;
      if (reset) begin
         for (int i = 0; i < CLUSTERS * WAYS; i++) begin
            slot_table[i] = '0;
         end
         fetch_answers.delete();
      end else begin
         // answers come only after their request has passed the core's registers, so check first
         if (rsp_valid) begin
            if (fetch_answers.size() == 0) begin
               report_error("response with no fetch outstanding");
            end else begin
               want = fetch_answers.pop_front();
               check_field("hit", int'(rsp_hit), int'(want.hit));
               check_field("depth", int'(rsp_out_depth), int'(want.depth));
               check_field("bound", int'(rsp_out_bound), int'(want.bound));
               check_field("age", int'(rsp_out_age), int'(want.age));
               check_field("move", int'(rsp_out_move), int'(want.move));
               check_field("score", int'(rsp_out_score), int'(want.score));
            end
         end
         if (start && !busy) begin
            if (req_action == chtpr_pkg::ACT_FETCH) begin
               fetch_answers.push_back(look_up(req_key));
            end else begin
               store_entry(req_key, req_depth, req_bound, req_age, req_best_move,
                           req_score, req_pv_node);
            end
         end
      end
      answers_owed <= fetch_answers.size();
   end

endmodule

// ===== bench/tb_top.sv =====
// tb_top: drives fetch and save requests into the probe/replace core and gives the verdict
// depends on chtpr_pkg, chtpr_checker and the core itself
`timescale 1ns / 1ps

module tb_top;

   localparam int CLUSTERS = chtpr_pkg::CLUSTERS_DEF;
   localparam int WAYS     = chtpr_pkg::WAYS_DEF;
   localparam int RANDOM_REQUESTS = 1500;

   localparam logic [9:0]  SHARED_CLUSTER = 10'h155;
   localparam logic [63:0] KEY_A = {54'h0000_0000_0001, SHARED_CLUSTER};
   localparam logic [63:0] KEY_B = {54'h2AA_AAAA_AAAA_AA, SHARED_CLUSTER};
   localparam logic [63:0] KEY_C = {54'h155_5555_5555_55, SHARED_CLUSTER};
   localparam logic [63:0] KEY_D = {54'h3FF_FFFF_0000_00, SHARED_CLUSTER};
   localparam logic [63:0] KEY_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic               req_action = chtpr_pkg::ACT_FETCH;
   logic [63:0]        req_key = '0;
   logic [7:0]         req_depth = '0;
   logic [7:0]         req_bound = '0;
   logic [7:0]         req_age = '0;
   logic [15:0]        req_best_move = '0;
   logic signed [15:0] req_score = '0;
   logic               req_pv_node = 1'b0;
   logic               rsp_valid;
   logic               rsp_hit;
   logic [7:0]         rsp_out_depth;
   logic [7:0]         rsp_out_bound;
   logic [7:0]         rsp_out_age;
   logic [15:0]        rsp_out_move;
   logic signed [15:0] rsp_out_score;

   int   fail_count;
   int   answers_owed;
   logic gaps_on = 1'b1;

   logic [9:0]  hot_cluster [6];
   logic [53:0] hot_high [5];
   logic [7:0]  generation = 8'd0;

   always #5 clock = ~clock;

   clustered_hash_table_probe_replace_core #(.CLUSTERS(CLUSTERS), .WAYS(WAYS)) DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_action(req_action), .req_key(req_key), .req_depth(req_depth),
      .req_bound(req_bound), .req_age(req_age), .req_best_move(req_best_move),
      .req_score(req_score), .req_pv_node(req_pv_node),
      .rsp_valid(rsp_valid), .rsp_hit(rsp_hit), .rsp_out_depth(rsp_out_depth),
      .rsp_out_bound(rsp_out_bound), .rsp_out_age(rsp_out_age),
      .rsp_out_move(rsp_out_move), .rsp_out_score(rsp_out_score)
   );

   chtpr_checker #(.CLUSTERS(CLUSTERS), .WAYS(WAYS)) u_checker (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_action(req_action), .req_key(req_key), .req_depth(req_depth),
      .req_bound(req_bound), .req_age(req_age), .req_best_move(req_best_move),
      .req_score(req_score), .req_pv_node(req_pv_node),
      .rsp_valid(rsp_valid), .rsp_hit(rsp_hit), .rsp_out_depth(rsp_out_depth),
      .rsp_out_bound(rsp_out_bound), .rsp_out_age(rsp_out_age),
      .rsp_out_move(rsp_out_move), .rsp_out_score(rsp_out_score),
      .fail_count(fail_count), .answers_owed(answers_owed)
   );

   // present one request, with random idle cycles ahead of it, and hold until taken
   task automatic issue(logic action, logic [63:0] key, logic [7:0] depth, logic [7:0] bound,
                        logic [7:0] age, logic [15:0] move, logic signed [15:0] score,
                        logic pv);
      logic stalled;
      while (gaps_on && $urandom_range(0, 99) < 29) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start         <= 1'b1;
      req_action    <= action;
      req_key       <= key;
      req_depth     <= depth;
      req_bound     <= bound;
      req_age       <= age;
      req_best_move <= move;
      req_score     <= score;
      req_pv_node   <= pv;
      // busy only moves at rising edges, so its value at the falling edge is what the core sees
      do begin
         @(negedge clock);
         stalled = busy;
         @(posedge clock);
      end while (stalled);
   endtask

   task automatic fetch(logic [63:0] key);
      issue(chtpr_pkg::ACT_FETCH, key, 8'($urandom), 8'($urandom), 8'($urandom),
            16'($urandom), 16'($urandom), 1'($urandom));
   endtask

   task automatic save(logic [63:0] key, logic [7:0] depth, logic [7:0] age, logic pv);
      issue(chtpr_pkg::ACT_SAVE, key, depth, 8'($urandom), age, 16'($urandom),
            16'($urandom), pv);
   endtask

   task automatic wait_all_answered();
      start <= 1'b0;
      do @(negedge clock); while (answers_owed != 0);
      @(posedge clock);
   endtask

   function automatic logic [63:0] pick_key();
      if ($urandom_range(0, 99) < 20) begin
         return {32'($urandom), 32'($urandom)};
      end
      return {hot_high[$urandom_range(0, 4)], hot_cluster[$urandom_range(0, 5)]};
   endfunction

   initial begin
      int shift;
      for (int i = 0; i < 6; i++) hot_cluster[i] = 10'($urandom);
      for (int i = 0; i < 5; i++) hot_high[i] = {22'($urandom), 32'($urandom)};
      hot_cluster[0] = 10'd0;
      hot_high[0]    = '0;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // empty table, key zero must not hit
      fetch(64'd0);
      fetch(KEY_ONES);
      issue(chtpr_pkg::ACT_SAVE, 64'd0, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, -16'sd32768, 1'b1);
      fetch(64'd0);
      issue(chtpr_pkg::ACT_SAVE, KEY_ONES, 8'h00, 8'h00, 8'h00, 16'h0000, 16'sd32767, 1'b0);
      fetch(KEY_ONES);
      // second save of the same key lands in the next empty way
      save(KEY_A, 8'd5, 8'd10, 1'b0);
      save(KEY_A, 8'd7, 8'd10, 1'b0);
      fetch(KEY_A);
      save(KEY_B, 8'd3, 8'd10, 1'b0);
      save(KEY_C, 8'd3, 8'd10, 1'b0);
      // full cluster with no matching way falls back to way 0
      save(KEY_D, 8'd9, 8'd10, 1'b0);
      fetch(KEY_A);
      fetch(KEY_D);
      // stale by two generations replaces the match
      save(KEY_A, 8'd1, 8'd12, 1'b0);
      // one generation apart only replaces a deeper entry on a pv node
      save(KEY_A, 8'd0, 8'd13, 1'b1);
      fetch(KEY_A);
      save(KEY_A, 8'd200, 8'd13, 1'b1);
      fetch(KEY_D);
      // both copies stale, the later way wins
      save(KEY_A, 8'd50, 8'd20, 1'b0);
      // an age below the stored one is not stale; ages compare without wrap, so 255 is stale against 10
      save(KEY_B, 8'd4, 8'd0, 1'b0);
      save(KEY_C, 8'd4, 8'd255, 1'b0);
      fetch(KEY_A);
      fetch(KEY_B);
      fetch(KEY_C);
      wait_all_answered();

      for (int n = 0; n < RANDOM_REQUESTS; n++) begin
         logic [7:0] age;
         logic [7:0] depth;
         gaps_on = !(n >= 600 && n < 800);
         if (n == 400 || n == 1100) wait_all_answered();
         if ($urandom_range(0, 99) < 6) generation = generation + 8'($urandom_range(1, 3));
         shift = $urandom_range(0, 99);
         if (shift < 10) age = 8'($urandom);
         else age = generation + 8'($urandom_range(0, 3)) - 8'd1;
         if ($urandom_range(0, 99) < 70) depth = 8'($urandom_range(0, 15));
         else depth = 8'($urandom);
         if ($urandom_range(0, 99) < 45) begin
            fetch(pick_key());
         end else begin
            issue(chtpr_pkg::ACT_SAVE, pick_key(), depth, 8'($urandom), age, 16'($urandom),
                  16'($urandom), 1'($urandom));
         end
      end

      wait_all_answered();
      repeat (20) @(posedge clock);
      if (fail_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/chtpr_pkg.sv
rtl/chtpr_queue.sv
rtl/chtpr_front.sv
rtl/chtpr_back.sv
rtl/clustered_hash_table_probe_replace_core.sv
bench/chtpr_checker.sv
bench/tb_top.sv
